FILE: hw/rtl/gru_pkg.sv
// ----------------------------------------------------------------------------
// gru_pkg: shared types and constants of the reaction update block
// Table geometry, field widths, action codes and sequencer states.
// ----------------------------------------------------------------------------
package gru_pkg;

	localparam int MaxReactions = 64;
	localparam int MaxSpecies   = 64;
	localparam int MaxProducts  = 5;

	localparam int RxnW   = $clog2(MaxReactions);
	localparam int SpecW  = 6;
	localparam int CountW = 31;
	localparam int RateW  = 32;
	localparam int PropW  = 63;
	localparam int LimbW  = 32;
	localparam int Limbs  = 6;
	localparam int AccW   = LimbW * Limbs;

	// reaction table entry layout
	localparam int TblW = 2 + 2 * SpecW + 3 + MaxProducts * SpecW + RateW;

	localparam logic [CountW-1:0] CountMax = '1;

	typedef enum logic [1:0] {
		ACT_SET_COUNT = 2'd0,
		ACT_WRITE_RXN = 2'd1,
		ACT_FIRE      = 2'd2,
		ACT_EMIT_ALL  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_REACTION_COUNT = 2'd0,
		CFG_SOURCE_FACTOR  = 2'd1,
		CFG_PAIR_FACTOR    = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FRD,
		ST_FLAT,
		ST_URD,
		ST_UWR,
		ST_SRD,
		ST_SCHK,
		ST_CRD0,
		ST_CRD1,
		ST_CLAT,
		ST_MUL,
		ST_MWAIT,
		ST_OUT,
		ST_FLUSH
	} gru_state_t;

	typedef struct packed {
		logic [1:0]               rc;
		logic [2*SpecW-1:0]       rs;
		logic [2:0]               pc;
		logic [MaxProducts*SpecW-1:0] ps;
		logic [RateW-1:0]         rate;
	} rxn_t;

endpackage

FILE: hw/rtl/gru_mul.sv
// ----------------------------------------------------------------------------
// gru_mul: limb-serial wide multiplier
// Multiplies a 192-bit operand by a 64-bit operand, result truncated to 192
// bits, one 32x32 partial product per cycle into a registered accumulator.
// ----------------------------------------------------------------------------
module gru_mul
	import gru_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [AccW-1:0]   a,
	input  logic [63:0]       v,
	output logic              done,
	output logic [AccW-1:0]   p
);

	logic [3:0]        k_q;
	logic              run_q;
	logic [63:0]       prod_s1;
	logic [2:0]        sh_s1;
	logic              pv_s1;
	logic              last_s1;
	logic              done_q;
	logic [AccW-1:0]   acc_q;

	logic              j_sel;
	logic [2:0]        i_sel;
	logic [3:0]        sh_sum;
	logic [LimbW-1:0]  a_limb;
	logic [LimbW-1:0]  v_limb;

	// limb selection for step k: v limb j = k/6, a limb i = k%6
	always_comb begin
		j_sel  = (k_q >= 4'd6);
		i_sel  = j_sel ? 3'(k_q - 4'd6) : k_q[2:0];
		sh_sum = {1'b0, i_sel} + {3'b0, j_sel};
		a_limb = a[LimbW*i_sel +: LimbW];
		v_limb = j_sel ? v[63:32] : v[31:0];
	end

	// issue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			k_q     <= '0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= last_s1;
			last_s1 <= run_q && (k_q == 4'd11);
			pv_s1   <= run_q && (sh_sum < 4'd6);
			if (start) begin
				run_q <= 1'b1;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + 4'd1;
				if (k_q == 4'd11) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// partial product and accumulate
	always_ff @(posedge clk) begin
		prod_s1 <= a_limb * v_limb;
		sh_s1   <= sh_sum[2:0];
		if (start) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + (AccW'(prod_s1) << (LimbW * sh_s1));
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

FILE: hw/rtl/gillespie_reaction_update.sv
// ----------------------------------------------------------------------------
// gillespie_reaction_update: species counts, reaction table, propensities
// Sequencer over the count and reaction memories with one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  s_* carries one command per transfer: s_tuser holds the action, s_tdata
//  the operands. m_* carries one propensity result per transfer, m_tlast
//  on the last result of a command. cfg_* writes a register.
//  Set count and write reaction complete at the transfer; the block stays ready.
//  A fire reads the reaction, then visits each of the 7 update slots, reading
//  the species count and writing it back where the slot is in use, then reads
//  and checks each reaction in turn. Every reported reaction adds two count
//  reads and one multiply, or three chained multiplies for two reactants;
//  each 192x64 multiply takes 12 steps through the single 32x32 multiplier
//  plus issue and drain, then the result is handed off.
//  Emit-all costs the same per reaction.
//  A result is held back one step so that tlast can be set; one finished
//  result waits in the output register while the next is computed. When the
//  receiver stalls the sequencer waits at the next result. After reset all
//  counts read zero, reaction_count is 1, factors are 0; the reaction table
//  holds nothing until written. s_tready is high only while idle.
// ----------------------------------------------------------------------------
module gillespie_reaction_update
	import gru_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// tdata: index[5:0], count_value[36:6], reactant_count[38:37],
	// reactant_first[44:39], reactant_second[50:45], product_count[53:51],
	// product_list[83:54], rate_value[115:84], zero pad [119:116]
	input  logic [119:0] s_tdata,
	// tuser: action[1:0]
	input  logic [1:0]   s_tuser,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: reaction_index[5:0], propensity[68:6], zero pad [71:69]
	output logic [71:0]  m_tdata,
	output logic         m_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [47:0]  cfg_data
);

	// configuration
	logic [6:0]  reaction_count_q;
	logic [39:0] source_factor_q;
	logic [47:0] pair_factor_q;
	logic [6:0]  nr;

	// memories
	logic [CountW-1:0] cnt_mem [MaxSpecies];
	logic [MaxSpecies-1:0] vld_q;
	logic [CountW-1:0] cnt_rd_q;
	logic [TblW-1:0]   tbl_mem [MaxReactions];
	rxn_t              tbl_rd_q;

	logic              cnt_we;
	logic [SpecW-1:0]  cnt_wa;
	logic [CountW-1:0] cnt_wd;
	logic [SpecW-1:0]  cnt_addr;
	logic              tbl_we;
	logic [RxnW-1:0]   tbl_addr;
	rxn_t              tbl_wd;

	// sequencer state
	gru_state_t state_q, state_d;
	logic [RxnW-1:0]  idx_q;
	logic             all_q;
	logic [2:0]       u_q;
	logic [RxnW-1:0]  n_q;
	rxn_t             fire_q;
	logic [1:0]       r_rc_q;
	logic [SpecW-1:0] r_s0_q;
	logic [SpecW-1:0] r_s1_q;
	logic [RateW-1:0] r_rate_q;
	logic [CountW-1:0] c1_q;
	logic [CountW-1:0] c2_q;
	logic [1:0]       mstep_q;
	logic [AccW-1:0]  a_q;

	// result staging
	logic             pend_v_q;
	logic [RxnW-1:0]  pend_idx_q;
	logic [PropW-1:0] pend_prop_q;
	logic             out_v_q;
	logic [RxnW-1:0]  out_idx_q;
	logic [PropW-1:0] out_prop_q;
	logic             out_last_q;

	// input fields
	logic [RxnW-1:0]   in_index;
	logic [CountW-1:0] in_count;
	logic [1:0]        in_rc;
	logic [2:0]        in_pc;
	logic              in_xfer;
	action_t           in_action;

	assign in_action = action_t'(s_tuser);
	assign in_index  = s_tdata[5:0];
	assign in_count  = s_tdata[36:6];
	assign in_rc     = s_tdata[38:37];
	assign in_pc     = s_tdata[53:51];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign nr        = (reaction_count_q > 7'(MaxReactions)) ? 7'(MaxReactions)
		: reaction_count_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reaction_count_q <= 7'd1;
			source_factor_q  <= '0;
			pair_factor_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REACTION_COUNT: reaction_count_q <= cfg_data[6:0];
				CFG_SOURCE_FACTOR:  source_factor_q  <= cfg_data[39:0];
				CFG_PAIR_FACTOR:    pair_factor_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// count memory with valid bits, registered read
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= vld_q[cnt_addr] ? cnt_mem[cnt_addr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cnt_we) begin
			vld_q[cnt_wa] <= 1'b1;
		end
	end

	// reaction table, registered read
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_addr] <= tbl_wd;
		end
		tbl_rd_q <= rxn_t'(tbl_mem[tbl_addr]);
	end

	// update op: reactants decrement, then products increment
	logic             u_act;
	logic [SpecW-1:0] u_sp;
	logic [CountW-1:0] u_new;

	always_comb begin
		u_act = 1'b0;
		u_sp  = '0;
		unique case (u_q)
			3'd0: begin u_act = (fire_q.rc >= 2'd1); u_sp = fire_q.rs[5:0]; end
			3'd1: begin u_act = (fire_q.rc >= 2'd2); u_sp = fire_q.rs[11:6]; end
			3'd2: begin u_act = (fire_q.pc >= 3'd1); u_sp = fire_q.ps[5:0]; end
			3'd3: begin u_act = (fire_q.pc >= 3'd2); u_sp = fire_q.ps[11:6]; end
			3'd4: begin u_act = (fire_q.pc >= 3'd3); u_sp = fire_q.ps[17:12]; end
			3'd5: begin u_act = (fire_q.pc >= 3'd4); u_sp = fire_q.ps[23:18]; end
			3'd6: begin u_act = (fire_q.pc >= 3'd5); u_sp = fire_q.ps[29:24]; end
			default: ;
		endcase
		if (u_q < 3'd2) begin
			u_new = (cnt_rd_q == '0) ? cnt_rd_q : cnt_rd_q - 1'b1;
		end else begin
			u_new = (cnt_rd_q == CountMax) ? cnt_rd_q : cnt_rd_q + 1'b1;
		end
	end

	// dependence of the scanned reaction on the fired one
	logic dep;
	always_comb begin
		dep = all_q;
		for (int j = 0; j < 2; j++) begin
			if (2'(j) < tbl_rd_q.rc) begin
				for (int k = 0; k < 2; k++) begin
					if (2'(k) < fire_q.rc &&
						fire_q.rs[SpecW*k +: SpecW] == tbl_rd_q.rs[SpecW*j +: SpecW]) begin
						dep = 1'b1;
					end
				end
				for (int k = 0; k < MaxProducts; k++) begin
					if (3'(k) < fire_q.pc &&
						fire_q.ps[SpecW*k +: SpecW] == tbl_rd_q.rs[SpecW*j +: SpecW]) begin
						dep = 1'b1;
					end
				end
			end
		end
	end

	// multiplier operand and output scaling
	logic            like;
	logic [63:0]     mul_v;
	logic            mul_start;
	logic            mul_done;
	logic [AccW-1:0] mul_p;
	logic [1:0]      mlast;
	logic [5:0]      out_sh;
	logic [AccW-1:0] shifted;
	logic [PropW-1:0] res;

	assign like = (r_s0_q == r_s1_q);

	always_comb begin
		mul_v = 64'(r_rate_q);
		if (r_rc_q == 2'd2) begin
			unique case (mstep_q)
				2'd0:    mul_v = 64'(c2_q);
				2'd1:    mul_v = 64'(r_rate_q);
				default: mul_v = 64'(pair_factor_q);
			endcase
		end
		mlast = (r_rc_q == 2'd2) ? 2'd2 : 2'd0;
		unique case (r_rc_q)
			2'd0:    out_sh = 6'd16;
			2'd1:    out_sh = 6'd0;
			default: out_sh = like ? 6'd49 : 6'd48;
		endcase
		shifted = a_q >> out_sh;
		res     = (|shifted[AccW-1:PropW]) ? '1 : shifted[PropW-1:0];
	end

	gru_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (a_q),
		.v      (mul_v),
		.done   (mul_done),
		.p      (mul_p)
	);

	logic out_free;
	logic last_n;
	assign out_free = !out_v_q || m_tready;
	assign last_n   = ({1'b0, n_q} + 7'd1 == nr);

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		cnt_we    = 1'b0;
		cnt_wa    = u_sp;
		cnt_wd    = u_new;
		cnt_addr  = u_sp;
		tbl_we    = 1'b0;
		tbl_addr  = n_q;
		tbl_wd.rc   = (in_rc == 2'd3) ? 2'd2 : in_rc;
		tbl_wd.rs   = s_tdata[50:39];
		tbl_wd.pc   = (in_pc > 3'(MaxProducts)) ? 3'(MaxProducts) : in_pc;
		tbl_wd.ps   = s_tdata[83:54];
		tbl_wd.rate = s_tdata[115:84];
		mul_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				tbl_addr = in_index;
				if (in_xfer) begin
					unique case (in_action)
						ACT_SET_COUNT: begin
							cnt_we = 1'b1;
							cnt_wa = in_index;
							cnt_wd = in_count;
						end
						ACT_WRITE_RXN: tbl_we = 1'b1;
						ACT_FIRE: begin
							if ({1'b0, in_index} < nr) state_d = ST_FRD;
						end
						default: begin
							if (nr != 7'd0) state_d = ST_SRD;
						end
					endcase
				end
			end
			ST_FRD: begin
				tbl_addr = idx_q;
				state_d  = ST_FLAT;
			end
			ST_FLAT: state_d = ST_URD;
			ST_URD: begin
				if (u_act) state_d = ST_UWR;
				else if (u_q == 3'd6) state_d = ST_SRD;
			end
			ST_UWR: begin
				cnt_we  = 1'b1;
				state_d = (u_q == 3'd6) ? ST_SRD : ST_URD;
			end
			ST_SRD: state_d = ST_SCHK;
			ST_SCHK: begin
				if (dep) state_d = ST_CRD0;
				else if (last_n) state_d = ST_FLUSH;
				else state_d = ST_SRD;
			end
			ST_CRD0: begin
				cnt_addr = r_s0_q;
				state_d  = ST_CRD1;
			end
			ST_CRD1: begin
				cnt_addr = r_s1_q;
				state_d  = ST_CLAT;
			end
			ST_CLAT: state_d = ST_MUL;
			ST_MUL: begin
				mul_start = 1'b1;
				state_d   = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (mul_done) state_d = (mstep_q == mlast) ? ST_OUT : ST_MUL;
			end
			ST_OUT: begin
				if (!pend_v_q || out_free) state_d = last_n ? ST_FLUSH : ST_SRD;
			end
			ST_FLUSH: begin
				if (!pend_v_q || out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			u_q     <= '0;
			n_q     <= '0;
			all_q   <= 1'b0;
			mstep_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					u_q     <= '0;
					n_q     <= '0;
					all_q   <= (in_action == ACT_EMIT_ALL);
				end
				ST_URD: if (!u_act) u_q <= u_q + 3'd1;
				ST_UWR: u_q <= u_q + 3'd1;
				ST_SCHK: if (!dep && !last_n) n_q <= n_q + 1'b1;
				ST_CLAT: mstep_q <= '0;
				ST_MWAIT: if (mul_done && mstep_q != mlast) mstep_q <= mstep_q + 2'd1;
				ST_OUT: begin
					if ((!pend_v_q || out_free) && !last_n) n_q <= n_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) idx_q <= in_index;
		if (state_q == ST_FLAT) fire_q <= tbl_rd_q;
		if (state_q == ST_SCHK) begin
			r_rc_q   <= tbl_rd_q.rc;
			r_s0_q   <= tbl_rd_q.rs[5:0];
			r_s1_q   <= tbl_rd_q.rs[11:6];
			r_rate_q <= tbl_rd_q.rate;
		end
		if (state_q == ST_CRD1) c1_q <= cnt_rd_q;
		if (state_q == ST_CLAT) begin
			if (like) c2_q <= (c1_q == '0) ? c1_q : c1_q - 1'b1;
			else c2_q <= cnt_rd_q;
			a_q <= (r_rc_q == 2'd0) ? AccW'(source_factor_q) : AccW'(c1_q);
		end
		if (state_q == ST_MWAIT && mul_done) a_q <= mul_p;
	end

	// pending result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if ((state_q == ST_OUT || state_q == ST_FLUSH) && pend_v_q && out_free) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == ST_OUT && (!pend_v_q || out_free)) pend_v_q <= 1'b1;
			else if (state_q == ST_FLUSH && out_free) pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT || state_q == ST_FLUSH) && pend_v_q && out_free) begin
			out_idx_q  <= pend_idx_q;
			out_prop_q <= pend_prop_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
		if (state_q == ST_OUT && (!pend_v_q || out_free)) begin
			pend_idx_q  <= n_q;
			pend_prop_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b0, out_prop_q, out_idx_q};

	// checks
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("pending result left behind at idle");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MWAIT)
		else $error("multiplier finished outside wait state");

	a_cnt_write: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (state_q == ST_IDLE || state_q == ST_UWR))
		else $error("count write outside set or update");

	a_mstep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MWAIT |-> mstep_q <= mlast)
		else $error("multiply step beyond chain");

endmodule

FILE: tb/tb_gillespie_reaction_update.sv
// ----------------------------------------------------------------------------
// tb_gillespie_reaction_update: self-checking bench of the reaction update block
// Loads the reaction table, runs a directed table of commands, then random
// phases under several register settings. Every propensity transfer is compared
// against an in-bench predictor or a pinned value, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_gillespie_reaction_update
	import gru_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 40000;

	typedef struct {
		action_t     act;
		logic [5:0]  idx;
		logic [30:0] count;
		logic [1:0]  rc;
		logic [5:0]  r1;
		logic [5:0]  r2;
		logic [2:0]  pc;
		logic [29:0] plist;
		logic [31:0] rate;
	} cmd_t;

	typedef struct {
		logic [5:0]  rxn;
		logic [62:0] prop;
		logic        last;
	} prop_t;

	// directed row: pinned = -1 uses the predictor, 0 or 1 is the typed count
	typedef struct {
		cmd_t        c;
		int          pinned;
		logic [62:0] pinned_prop;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic [119:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  m_tdata;
	logic         m_tlast;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [47:0]  cfg_data = '0;

	// predictor state
	logic [30:0] counts [64];
	logic [1:0]  rx_rc [64];
	logic [11:0] rx_rs [64];
	logic [2:0]  rx_pc [64];
	logic [29:0] rx_ps [64];
	logic [31:0] rx_rate [64];
	logic [6:0]  rxn_limit;
	logic [39:0] src_factor;
	logic [47:0] pr_factor;

	prop_t pending_props [$];
	int    fails = 0;
	int    idle_cycles = 0;
	bit    quiet = 1'b0;

	gillespie_reaction_update dut (.*);

	always #4 clk = ~clk;

	function automatic int active_rxns();
		return (rxn_limit > 7'd64) ? 64 : int'(rxn_limit);
	endfunction

	// exact product, shifted and saturated to 63 bits
	function automatic logic [62:0] propensity(int r);
		logic [191:0] acc;
		logic [191:0] c1;
		logic [191:0] c2;
		int           sh;
		logic [5:0]   s0;
		logic [5:0]   s1;
		s0 = rx_rs[r][5:0];
		s1 = rx_rs[r][11:6];
		if (rx_rc[r] == 2'd0) begin
			acc = 192'(src_factor) * 192'(rx_rate[r]);
			sh = 16;
		end else if (rx_rc[r] == 2'd1) begin
			acc = 192'(counts[s0]) * 192'(rx_rate[r]);
			sh = 0;
		end else begin
			c1 = 192'(counts[s0]);
			c2 = 192'(counts[s1]);
			if (s0 == s1) c2 = (c1 == 0) ? 0 : c1 - 1;
			acc = c1 * c2 * 192'(rx_rate[r]) * 192'(pr_factor);
			sh = (s0 == s1) ? 49 : 48;
		end
		acc = acc >> sh;
		return (acc[191:63] != 0) ? '1 : acc[62:0];
	endfunction

	// apply one accepted command, return the propensities it reports
	function automatic void predict_cmd(cmd_t c, ref prop_t outq[$]);
		int     nr;
		bit     dep;
		logic [5:0] s;
		int     r;
		nr = active_rxns();
		r = int'(c.idx);
		outq = {};
		case (c.act)
			ACT_SET_COUNT: counts[c.idx] = c.count;
			ACT_WRITE_RXN: begin
				rx_rc[r] = (c.rc == 2'd3) ? 2'd2 : c.rc;
				rx_rs[r] = {c.r2, c.r1};
				rx_pc[r] = (c.pc > 3'd5) ? 3'd5 : c.pc;
				rx_ps[r] = c.plist;
				rx_rate[r] = c.rate;
			end
			ACT_EMIT_ALL: begin
				for (int n = 0; n < nr; n++)
					outq.push_back('{6'(n), propensity(n), n == nr - 1});
			end
			ACT_FIRE: begin
				if (r < nr) begin
					for (int k = 0; k < rx_rc[r]; k++) begin
						s = rx_rs[r][6*k +: 6];
						if (counts[s] != 0) counts[s]--;
					end
					for (int k = 0; k < rx_pc[r]; k++) begin
						s = rx_ps[r][6*k +: 6];
						if (counts[s] != CountMax) counts[s]++;
					end
					for (int n = 0; n < nr; n++) begin
						dep = 1'b0;
						for (int j = 0; j < rx_rc[n]; j++) begin
							s = rx_rs[n][6*j +: 6];
							for (int k = 0; k < rx_rc[r]; k++)
								if (rx_rs[r][6*k +: 6] == s) dep = 1'b1;
							for (int k = 0; k < rx_pc[r]; k++)
								if (rx_ps[r][6*k +: 6] == s) dep = 1'b1;
						end
						if (dep) outq.push_back('{6'(n), propensity(n), 1'b0});
					end
					if (outq.size() > 0) outq[outq.size()-1].last = 1'b1;
				end
			end
		endcase
	endfunction

	// one command transfer; valid stays high between back-to-back commands
	task automatic send_cmd(cmd_t c, int pinned, logic [62:0] pinned_prop);
		int   gap;
		prop_t props [$];
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.act;
		s_tdata <= {4'b0, c.rate, c.plist, c.pc, c.r2, c.r1, c.rc, c.count, c.idx};
		do @(posedge clk); while (!s_tready);
		predict_cmd(c, props);
		if (pinned >= 0) begin
			props = {};
			if (pinned == 1) props.push_back('{6'd0, pinned_prop, 1'b1});
		end
		foreach (props[i]) pending_props.push_back(props[i]);
	endtask

	// wait for the block to drain, then write all three registers
	task automatic write_regs(logic [6:0] rc, logic [39:0] sf, logic [47:0] pf);
		s_tvalid <= 1'b0;
		wait (pending_props.size() == 0);
		do @(posedge clk); while (!s_tready);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_REACTION_COUNT;
		cfg_data <= 48'(rc);
		@(posedge clk);
		cfg_index <= CFG_SOURCE_FACTOR;
		cfg_data <= 48'(sf);
		@(posedge clk);
		cfg_index <= CFG_PAIR_FACTOR;
		cfg_data <= pf;
		@(posedge clk);
		cfg_we <= 1'b0;
		rxn_limit = rc;
		src_factor = sf;
		pr_factor = pf;
	endtask

	// species mostly from a small pool so that fires have dependents
	function automatic logic [5:0] pick_species();
		return ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7)) : 6'($urandom);
	endfunction

	function automatic logic [30:0] pick_count();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return CountMax;
			2: return CountMax - 31'($urandom_range(0, 3));
			3: return 31'($urandom_range(0, 20));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic cmd_t rand_write(logic [5:0] idx);
		cmd_t c;
		c.act = ACT_WRITE_RXN;
		c.idx = idx;
		c.count = 31'($urandom);
		c.rc = 2'($urandom);
		c.r1 = pick_species();
		c.r2 = ($urandom_range(0, 3) == 0) ? c.r1 : pick_species();
		c.pc = 3'($urandom);
		c.plist = {pick_species(), pick_species(), pick_species(), pick_species(),
			pick_species()};
		if ($urandom_range(0, 7) == 0) c.plist = 30'($urandom);
		c.rate = ($urandom_range(0, 5) == 0) ? '1 : 32'($urandom);
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   pick;
		int   nr;
		nr = active_rxns();
		pick = $urandom_range(0, 99);
		c = rand_write(6'($urandom));
		if (pick < 30) begin
			c.act = ACT_SET_COUNT;
			c.idx = pick_species();
			c.count = pick_count();
		end else if (pick < 45) begin
			c.act = ACT_WRITE_RXN;
		end else if (pick < 95) begin
			c.act = ACT_FIRE;
			if (nr > 0 && $urandom_range(0, 9) != 0) c.idx = 6'($urandom_range(0, nr - 1));
		end else begin
			c.act = ACT_EMIT_ALL;
		end
		return c;
	endfunction

	// result checker with random stalls
	initial begin
		int    w;
		prop_t got;
		prop_t want;
		wait (arst_n);
		forever begin
			w = quiet ? 0 : $urandom_range(0, 5);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			got = '{m_tdata[5:0], m_tdata[68:6], m_tlast};
			if (pending_props.size() == 0) begin
				$error("unexpected result: reaction_index %0d propensity %0h",
					got.rxn, got.prop);
				fails++;
			end else begin
				want = pending_props.pop_front();
				if (got.rxn !== want.rxn) begin
					$error("reaction_index: expected %0d, got %0d", want.rxn, got.rxn);
					fails++;
				end
				if (got.prop !== want.prop) begin
					$error("propensity: expected %0h, got %0h", want.prop, got.prop);
					fails++;
				end
				if (got.last !== want.last) begin
					$error("last_flag: expected %0b, got %0b", want.last, got.last);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("** gillespie_reaction_update: FAILED **");
			$finish;
		end
	end

	// stimulus
	initial begin
		row_t  rows [$];
		cmd_t  c;
		logic [6:0]  ph_rc [5];
		logic [39:0] ph_sf [5];
		logic [47:0] ph_pf [5];

		for (int i = 0; i < 64; i++) begin
			counts[i] = '0;
			rx_rc[i] = '0;
			rx_rs[i] = '0;
			rx_pc[i] = '0;
			rx_ps[i] = '0;
			rx_rate[i] = '0;
		end
		rxn_limit = 7'd1;
		src_factor = '0;
		pr_factor = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole reaction table first
		write_regs(7'd64, 40'd1 << 16, 48'd1 << 40);
		for (int i = 0; i < 64; i++) send_cmd(rand_write(6'(i)), -1, '0);

		// directed table, four reactions in use
		write_regs(7'd4, 40'd1 << 16, '1);
		c = rand_write(6'd0);
		c.act = ACT_SET_COUNT; c.idx = 6'd0; c.count = 31'd10;
		rows.push_back('{c, -1, '0});
		c.idx = 6'd1; c.count = CountMax;
		rows.push_back('{c, -1, '0});
		c.idx = 6'd2; c.count = '0;
		rows.push_back('{c, -1, '0});
		// single reactant on species 0, rate 1.0
		c = '{ACT_WRITE_RXN, 6'd0, '0, 2'd1, 6'd0, 6'd0, 3'd0, '0, 32'h0001_0000};
		rows.push_back('{c, -1, '0});
		// source reaction producing species 2, highest rate
		c = '{ACT_WRITE_RXN, 6'd1, '1, 2'd0, 6'd63, 6'd63, 3'd1, 30'd2, '1};
		rows.push_back('{c, -1, '0});
		// like reactants on species 1, five products on species 3
		c = '{ACT_WRITE_RXN, 6'd2, '0, 2'd2, 6'd1, 6'd1, 3'd5, {5{6'd3}}, '1};
		rows.push_back('{c, -1, '0});
		// reactant count 3 and product count 7 are clipped
		c = '{ACT_WRITE_RXN, 6'd3, '0, 2'd3, 6'd1, 6'd2, 3'd7, 30'h3FFF_FFFF, 32'h8000_0001};
		rows.push_back('{c, -1, '0});
		c = '{ACT_FIRE, 6'd0, '0, '0, '0, '0, '0, '0, '0};
		rows.push_back('{c, 1, 63'h9_0000});
		c.act = ACT_EMIT_ALL;
		rows.push_back('{c, -1, '0});
		c.act = ACT_FIRE; c.idx = 6'd1;
		rows.push_back('{c, -1, '0});
		c.idx = 6'd2;
		rows.push_back('{c, -1, '0});
		c.idx = 6'd3;
		rows.push_back('{c, -1, '0});
		// fire beyond the reactions in use is dropped
		c.idx = 6'd5;
		rows.push_back('{c, 0, '0});
		c.idx = 6'd63;
		rows.push_back('{c, 0, '0});
		c = '{ACT_SET_COUNT, 6'd0, '0, '0, '0, '0, '0, '0, '0};
		rows.push_back('{c, -1, '0});
		// count already zero stays zero
		c = '{ACT_FIRE, 6'd0, '0, '0, '0, '0, '0, '0, '0};
		rows.push_back('{c, 1, '0});
		c.act = ACT_EMIT_ALL;
		rows.push_back('{c, -1, '0});
		foreach (rows[i]) send_cmd(rows[i].c, rows[i].pinned, rows[i].pinned_prop);

		// random phases over register settings
		ph_rc = '{7'd64, 7'd0, 7'd127, 7'd1, 7'($urandom_range(2, 64))};
		ph_sf = '{'1, 40'($urandom), '0, 40'($urandom), 40'($urandom)};
		ph_pf = '{'1, '0, 48'($urandom) << 16 | 48'($urandom), 48'($urandom), '1};
		for (int p = 0; p < 5; p++) begin
			write_regs(ph_rc[p], ph_sf[p], ph_pf[p]);
			for (int i = 0; i < 50; i++) begin
				quiet = (i >= 35);
				send_cmd(rand_cmd(), -1, '0);
			end
			quiet = 1'b0;
		end

		s_tvalid <= 1'b0;
		wait (pending_props.size() == 0);
		repeat (100) @(posedge clk);
		if (fails == 0) begin
			$display("** gillespie_reaction_update: PASSED **");
		end else begin
			$display("** gillespie_reaction_update: FAILED **");
		end
		$finish;
	end

endmodule
